[hdl/sndf_pkg.sv]
package sndf_pkg;

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   localparam logic [7:0] SX_START = 8'hF0;
   localparam logic [7:0] SX_END   = 8'hF7;

   localparam logic [6:0] MFR_RESET       = 7'd16;
   localparam logic [6:0] DEV_RESET       = 7'd6;
   localparam logic [6:0] OP_PATCH_RESET  = 7'd1;
   localparam logic [6:0] OP_EDIT_RESET   = 7'd13;
   localparam logic [6:0] OP_MASTER_RESET = 7'd3;

   // register index, paddr[4:2]
   localparam logic [2:0] REG_MFR       = 3'd0;
   localparam logic [2:0] REG_DEV       = 3'd1;
   localparam logic [2:0] REG_OP_PATCH  = 3'd2;
   localparam logic [2:0] REG_OP_EDIT   = 3'd3;
   localparam logic [2:0] REG_OP_MASTER = 3'd4;

   localparam logic [1:0] KIND_PATCH  = 2'd0;
   localparam logic [1:0] KIND_EDIT   = 2'd1;
   localparam logic [1:0] KIND_MASTER = 2'd2;

   typedef logic [3:0] step_type;

   // position of each byte within the framed message
   localparam step_type STEP_START = 4'd0;
   localparam step_type STEP_MFR   = 4'd1;
   localparam step_type STEP_DEV   = 4'd2;
   localparam step_type STEP_OP    = 4'd3;
   localparam step_type STEP_HDR   = 4'd4;
   localparam step_type STEP_LOW   = 4'd5;
   localparam step_type STEP_HIGH  = 4'd6;
   localparam step_type STEP_SUM   = 4'd7;
   localparam step_type STEP_END   = 4'd8;

endpackage

[hdl/sysex_nibble_dump_framer_unit.sv]
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | data_byte, first_byte, last_byte, kind, header
// rsp     | out       | rsp_valid/rsp_stall | out_byte, end_of_message
// csr     | in/out    | APB, pready high    | five 7-bit registers at 4*i
//
// One result byte leaves the output register per cycle while rsp is not stalled; an item
// yields 2 to 9 bytes (2 per plain data byte, 7 with a header, 4 with the closing checksum).
// The next item is taken in the cycle its predecessor issues its final byte. Reset
// (synchronous) restores the registers and clears the sum.
// A stalled rsp holds the output register and keeps req_stall high while an item is in
// progress; an idle unit still takes one item.
module sysex_nibble_dump_framer_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_first_byte,
   input  logic                       req_last_byte,
   input  logic [1:0]                 req_message_kind,
   input  logic [7:0]                 req_header_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_end_of_message,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [sndf_pkg::ADDR_W-1:0] paddr,
   input  logic [sndf_pkg::DATA_W-1:0] pwdata,
   output logic [sndf_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import sndf_pkg::*;

   logic [6:0] mfr_ff, dev_ff, op_patch_ff, op_edit_ff, op_master_ff;
   logic       cfg_wr;
   logic [2:0] cfg_idx;

   logic       busy_ff, busy_in;
   step_type   step_ff, step_in;
   logic [7:0] data_ff, hval_ff;
   logic       last_ff;
   logic [1:0] kind_ff;
   logic [6:0] csum_ff;
   logic [6:0] sum_ff, sum_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_eom_ff;

   logic       req_acc, out_free, load, done;
   step_type   step_last;
   logic [7:0] cur_byte, op_byte;

   // configuration port
   assign pready  = 1'b1;
   assign cfg_idx = paddr[ADDR_W-1:2];
   assign cfg_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mfr_ff       <= MFR_RESET;
         dev_ff       <= DEV_RESET;
         op_patch_ff  <= OP_PATCH_RESET;
         op_edit_ff   <= OP_EDIT_RESET;
         op_master_ff <= OP_MASTER_RESET;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            REG_MFR:       mfr_ff       <= pwdata[6:0];
            REG_DEV:       dev_ff       <= pwdata[6:0];
            REG_OP_PATCH:  op_patch_ff  <= pwdata[6:0];
            REG_OP_EDIT:   op_edit_ff   <= pwdata[6:0];
            REG_OP_MASTER: op_master_ff <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         REG_MFR:       prdata = {{(DATA_W-7){1'b0}}, mfr_ff};
         REG_DEV:       prdata = {{(DATA_W-7){1'b0}}, dev_ff};
         REG_OP_PATCH:  prdata = {{(DATA_W-7){1'b0}}, op_patch_ff};
         REG_OP_EDIT:   prdata = {{(DATA_W-7){1'b0}}, op_edit_ff};
         REG_OP_MASTER: prdata = {{(DATA_W-7){1'b0}}, op_master_ff};
         default:       prdata = '0;
      endcase
   end

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_last = last_ff ? STEP_END : STEP_HIGH;
   assign load      = busy_ff && out_free;
   assign done      = load && (step_ff == step_last);
   assign req_stall = busy_ff && !done;
   assign req_acc   = req_valid && !req_stall;

   // byte selection for the current step
   always_comb begin
      case (kind_ff)
         KIND_PATCH: op_byte = {1'b0, op_patch_ff};
         KIND_EDIT:  op_byte = {1'b0, op_edit_ff};
         default:    op_byte = {1'b0, op_master_ff};
      endcase
   end

   always_comb begin
      unique case (step_ff)
         STEP_START: cur_byte = SX_START;
         STEP_MFR:   cur_byte = {1'b0, mfr_ff};
         STEP_DEV:   cur_byte = {1'b0, dev_ff};
         STEP_OP:    cur_byte = op_byte;
         STEP_HDR:   cur_byte = (kind_ff == KIND_EDIT) ? 8'h00 : hval_ff;
         STEP_LOW:   cur_byte = {4'h0, data_ff[3:0]};
         STEP_HIGH:  cur_byte = {4'h0, data_ff[7:4]};
         STEP_SUM:   cur_byte = {1'b0, csum_ff};
         STEP_END:   cur_byte = SX_END;
         default:    cur_byte = 8'h00;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      sum_in  = sum_ff;
      if (load) begin
         step_in = step_ff + 4'd1;
      end
      if (done) begin
         busy_in = 1'b0;
      end
      if (req_acc) begin
         busy_in = 1'b1;
         step_in = req_first_byte ? STEP_START : STEP_LOW;
         sum_in  = (req_first_byte ? 7'd0 : sum_ff) + req_data_byte[6:0];
      end
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_START;
         sum_ff       <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         data_ff <= req_data_byte;
         last_ff <= req_last_byte;
         kind_ff <= req_message_kind;
         hval_ff <= req_header_value;
         csum_ff <= sum_in;
      end
      if (load) begin
         rsp_byte_ff <= cur_byte;
         rsp_eom_ff  <= (step_ff == STEP_END);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = rsp_byte_ff;
   assign rsp_end_of_message = rsp_eom_ff;

   a_eom_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_eom_ff |-> rsp_byte_ff == SX_END)
      else $error("end of message on a byte other than the end byte");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= step_last)
      else $error("step beyond the item's final byte");

   a_acc_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> busy_ff)
      else $error("accepted item not held");

   a_no_lost_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_byte_ff))
      else $error("stalled result overwritten");

endmodule

[dv/sysex_nibble_dump_framer_checker.sv]
`timescale 1ns / 100ps

module sysex_nibble_dump_framer_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_first_byte,
   input  logic                          req_last_byte,
   input  logic [1:0]                    req_message_kind,
   input  logic [7:0]                    req_header_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [7:0]                    rsp_out_byte,
   input  logic                          rsp_end_of_message,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sndf_pkg::ADDR_W-1:0]   paddr,
   input  logic [sndf_pkg::DATA_W-1:0]   pwdata,
   input  logic [sndf_pkg::DATA_W-1:0]   prdata,
   input  logic                          pready,
   output int                            fail_count,
   output int                            pending_count,
   output int                            bytes_checked
);
   import sndf_pkg::*;

   typedef struct packed {
      logic [7:0] out_val;
      logic       eom;
   } frame_byte_type;

   frame_byte_type frame_q[$];

   logic [6:0] mfr_id    = MFR_RESET;
   logic [6:0] dev_id    = DEV_RESET;
   logic [6:0] op_patch  = OP_PATCH_RESET;
   logic [6:0] op_edit   = OP_EDIT_RESET;
   logic [6:0] op_master = OP_MASTER_RESET;
   logic [6:0] dump_sum  = '0;

   int errors  = 0;
   int matched = 0;

   task automatic queue_byte(input logic [7:0] value, input logic eom);
      frame_byte_type fb;
      fb.out_val = value;
      fb.eom     = eom;
      frame_q = {frame_q, fb};
   endtask

   function automatic logic [6:0] csr_value(logic [2:0] idx);
      case (idx)
         REG_MFR:       return mfr_id;
         REG_DEV:       return dev_id;
         REG_OP_PATCH:  return op_patch;
         REG_OP_EDIT:   return op_edit;
         REG_OP_MASTER: return op_master;
         default:       return '0;
      endcase
   endfunction

   // expected bytes for one accepted item
   task automatic frame_item(input logic [7:0] data, input logic first, input logic last,
                             input logic [1:0] kind, input logic [7:0] hval);
      logic [6:0] op;
      logic [7:0] hdr;
      if (first) begin
         hdr = hval;
         case (kind)
            KIND_PATCH: op = op_patch;
            KIND_EDIT: begin
               op  = op_edit;
               hdr = '0;
            end
            default: op = op_master;
         endcase
         dump_sum = '0;
         queue_byte(SX_START, 1'b0);
         queue_byte({1'b0, mfr_id}, 1'b0);
         queue_byte({1'b0, dev_id}, 1'b0);
         queue_byte({1'b0, op}, 1'b0);
         queue_byte(hdr, 1'b0);
      end
      queue_byte({4'h0, data[3:0]}, 1'b0);
      queue_byte({4'h0, data[7:4]}, 1'b0);
      dump_sum = dump_sum + data[6:0];
      if (last) begin
         queue_byte({1'b0, dump_sum}, 1'b0);
         queue_byte(SX_END, 1'b1);
      end
   endtask

   always @(posedge clock) begin : monitor
      frame_byte_type exp_byte;
      if (reset) begin
         mfr_id    = MFR_RESET;
         dev_id    = DEV_RESET;
         op_patch  = OP_PATCH_RESET;
         op_edit   = OP_EDIT_RESET;
         op_master = OP_MASTER_RESET;
         dump_sum  = '0;
         frame_q.delete();
      end else begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (paddr[4:2])
                  REG_MFR:       mfr_id    = pwdata[6:0];
                  REG_DEV:       dev_id    = pwdata[6:0];
                  REG_OP_PATCH:  op_patch  = pwdata[6:0];
                  REG_OP_EDIT:   op_edit   = pwdata[6:0];
                  REG_OP_MASTER: op_master = pwdata[6:0];
                  default: ;
               endcase
            end else if (prdata[6:0] !== csr_value(paddr[4:2])) begin
               errors++;
               $display("%0t: csr read at %02h expected %02h actual %02h", $time, paddr,
                        csr_value(paddr[4:2]), prdata[6:0]);
            end
         end
         if (req_valid && !req_stall)
            frame_item(req_data_byte, req_first_byte, req_last_byte, req_message_kind,
                       req_header_value);
         if (rsp_valid && !rsp_stall) begin
            if (frame_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected byte, expected none actual %02h eom %b", $time,
                        rsp_out_byte, rsp_end_of_message);
            end else begin
               exp_byte = frame_q.pop_front();
               matched++;
               if (rsp_out_byte !== exp_byte.out_val) begin
                  errors++;
                  $display("%0t: out_byte expected %02h actual %02h", $time,
                           exp_byte.out_val, rsp_out_byte);
               end
               if (rsp_end_of_message !== exp_byte.eom) begin
                  errors++;
                  $display("%0t: end_of_message expected %b actual %b", $time,
                           exp_byte.eom, rsp_end_of_message);
               end
            end
         end
      end
      fail_count    <= errors;
      pending_count <= frame_q.size();
      bytes_checked <= matched;
   end

endmodule

[dv/sysex_nibble_dump_framer_unit_test.sv]
`timescale 1ns / 100ps

module sysex_nibble_dump_framer_unit_test;
   import sndf_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 108;
   localparam logic [2:0] CSR_LIST[5] = '{REG_MFR, REG_DEV, REG_OP_PATCH, REG_OP_EDIT,
                                          REG_OP_MASTER};

   logic              clock              = 1'b0;
   logic              reset              = 1'b1;
   logic              req_valid          = 1'b0;
   logic              req_stall;
   logic [7:0]        req_data_byte      = '0;
   logic              req_first_byte     = 1'b0;
   logic              req_last_byte      = 1'b0;
   logic [1:0]        req_message_kind   = KIND_PATCH;
   logic [7:0]        req_header_value   = '0;
   logic              rsp_valid;
   logic              rsp_stall          = 1'b0;
   logic [7:0]        rsp_out_byte;
   logic              rsp_end_of_message;
   logic              psel               = 1'b0;
   logic              penable            = 1'b0;
   logic              pwrite             = 1'b0;
   logic [ADDR_W-1:0] paddr              = '0;
   logic [DATA_W-1:0] pwdata             = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   int fail_count;
   int pending_count;
   int bytes_checked;
   int cycle_count     = 0;
   int sent_items      = 0;
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;

   always #10 clock = ~clock;

   sysex_nibble_dump_framer_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_first_byte     (req_first_byte),
      .req_last_byte      (req_last_byte),
      .req_message_kind   (req_message_kind),
      .req_header_value   (req_header_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_end_of_message (rsp_end_of_message),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   sysex_nibble_dump_framer_checker frame_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_first_byte     (req_first_byte),
      .req_last_byte      (req_last_byte),
      .req_message_kind   (req_message_kind),
      .req_header_value   (req_header_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_end_of_message (rsp_end_of_message),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .bytes_checked      (bytes_checked)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sysex_nibble_dump_framer_unit test failed");
         $finish;
      end
   end

   task automatic send_item(input logic [7:0] data, input logic first, input logic last,
                            input logic [1:0] kind, input logic [7:0] hval);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= data;
      req_first_byte   <= first;
      req_last_byte    <= last;
      req_message_kind <= kind;
      req_header_value <= hval;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
   endtask

   // well-formed dump: first mark, random body, last mark
   task automatic send_dump(input int len);
      logic [1:0] kind;
      logic [7:0] hval;
      kind = 2'($urandom_range(3));
      hval = 8'($urandom);
      for (int i = 0; i < len; i++) begin
         if (i == 0)
            send_item(8'($urandom), 1'b1, len == 1, kind, hval);
         else
            send_item(8'($urandom), 1'b0, i == len - 1, 2'($urandom_range(3)),
                      8'($urandom));
      end
   endtask

   task automatic wait_empty(input int tail);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [2:0] idx,
                             input logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // 0: all zero, 1: all ones, else random; upper data bits are junk
   task automatic program_registers(input int mode);
      logic [6:0] value;
      for (int i = 0; i < 5; i++) begin
         value = (mode == 0) ? 7'h00 : (mode == 1) ? 7'h7F : 7'($urandom);
         csr_access(1'b1, CSR_LIST[i], ($urandom & ~32'h7F) | 32'(value));
      end
      for (int i = 0; i < 5; i++) csr_access(1'b0, CSR_LIST[i], '0);
   endtask

   initial begin : stimulus
      int phase_target;
      bit paused;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 5; i++) csr_access(1'b0, CSR_LIST[i], '0);

      // single-byte messages of each kind, kind 3 included
      send_item(8'h00, 1'b1, 1'b1, KIND_PATCH,  8'h00);
      send_item(8'hFF, 1'b1, 1'b1, KIND_EDIT,   8'hFF);
      send_item(8'h5A, 1'b1, 1'b1, KIND_MASTER, 8'h80);
      send_item(8'hA5, 1'b1, 1'b1, KIND_UNUSED, 8'h7F);
      // kind and header ignored off the first item
      send_item(8'h0F, 1'b1, 1'b0, KIND_PATCH,  8'h12);
      send_item(8'hF0, 1'b0, 1'b0, KIND_EDIT,   8'hFF);
      send_item(8'hFF, 1'b0, 1'b1, KIND_MASTER, 8'hAA);
      // sum carries on past a last mark
      send_item(8'h81, 1'b0, 1'b0, KIND_PATCH,  8'h55);
      send_item(8'h7F, 1'b0, 1'b1, KIND_UNUSED, 8'h00);
      // restart while a message is open
      send_item(8'h33, 1'b1, 1'b0, KIND_MASTER, 8'hC3);
      send_item(8'h44, 1'b0, 1'b0, KIND_PATCH,  8'h00);
      send_item(8'h55, 1'b1, 1'b0, KIND_EDIT,   8'h99);
      send_item(8'h66, 1'b0, 1'b1, KIND_PATCH,  8'h00);
      send_item(8'h80, 1'b1, 1'b1, KIND_PATCH,  8'hFE);
      send_item(8'hC8, 1'b1, 1'b0, KIND_PATCH,  8'h01);
      send_item(8'hC8, 1'b0, 1'b1, KIND_PATCH,  8'h00);
      wait_empty(12);

      for (int phase = 0; phase < 4; phase++) begin
         program_registers(phase);
         case (phase)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 88; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 88; end
            default: begin sender_idle_pct = 38; rsp_stall_pct = 38; end
         endcase
         phase_target = sent_items + PHASE_ITEMS;
         paused = 1'b0;
         while (sent_items < phase_target) begin
            if (!paused && sent_items > phase_target - PHASE_ITEMS / 2) begin
               paused = 1'b1;
               wait_empty(0);
            end
            if ($urandom_range(99) < 85)
               send_dump($urandom_range(1, 8));
            else
               send_item(8'($urandom), 1'($urandom), 1'($urandom), 2'($urandom_range(3)),
                         8'($urandom));
         end
         wait_empty(12);
      end

      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      $display("covered %0d input items: all kinds, restarts, open sums, four idle phases",
               sent_items);
      $display("register settings: reset, all zero, all ones, random; %0d bytes checked",
               bytes_checked);
      if (fail_count == 0 && pending_count == 0) begin
         $display("sysex_nibble_dump_framer_unit test passed");
      end else begin
         $display("sysex_nibble_dump_framer_unit test failed");
      end
      $finish;
   end

endmodule
